// File: sv/wmas_pkg.sv
`timescale 1ns / 1ps

package wmas_pkg;

	localparam int LANES        = 8;
	localparam int CHANNELS     = 8;
	localparam int WINDOW_LEN   = 8;
	localparam int SLOT_W       = $clog2(WINDOW_LEN);
	localparam int WEIGHT_W     = $clog2(WINDOW_LEN) + 1;
	localparam int WEIGHT_TOTAL = WINDOW_LEN * (WINDOW_LEN + 1) / 2;
	localparam int SAMPLE_W     = 16;
	localparam int LEVEL_W      = 13;
	localparam int PROD_W       = SAMPLE_W + WEIGHT_W;
	localparam int ACC_W        = $clog2(((1 << SAMPLE_W) - 1) * WEIGHT_TOTAL + 1);

	// sum / 36 == (sum >> 2) / 9; the reciprocal of 9 at 2^-23 is exact for 20-bit dividends
	localparam int DIV_PRE_SHIFT = 2;
	localparam int DIVIDEND_W    = ACC_W - DIV_PRE_SHIFT;
	localparam int RECIP_W       = 20;
	localparam int RECIP_SHIFT   = 23;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(932068);
	localparam int QUOT_PROD_W   = DIVIDEND_W + RECIP_W;

	localparam int SCALE_W     = 13;
	localparam logic [SCALE_W-1:0] SCALE_MUL = SCALE_W'(5000);
	localparam int SCALE_SHIFT = 16;
	localparam int SCALED_W    = SAMPLE_W + SCALE_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [LEVEL_W-1:0]  level_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef sample_t [LANES-1:0] samples_t;
	typedef level_t  [LANES-1:0] levels_t;

	typedef struct packed {
		slot_t    slot;
		samples_t samples;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ACC,
		BK_DIV,
		BK_MUL
	} bk_state_t;

endpackage

// File: sv/wmas_front.sv
`timescale 1ns / 1ps

module wmas_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  wmas_pkg::samples_t samples,
	output wmas_pkg::job_req_t req,
	input  logic              take
);
	import wmas_pkg::*;

	job_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	slot_t             write_slot_q;
	logic              accept;
	logic              deq;

	assign full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign accept = push && !full;
	assign deq    = take && (cnt_q != '0);

	// each transaction is stamped with the ring slot it will occupy
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q].slot    <= write_slot_q;
			fifo_q[wr_ptr_q].samples <= samples;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			cnt_q        <= '0;
			write_slot_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q     <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				write_slot_q <= write_slot_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({accept, deq})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign req.valid = (cnt_q != '0);
	assign req.job   = fifo_q[rd_ptr_q];

endmodule

// File: sv/wmas_back.sv
`timescale 1ns / 1ps

module wmas_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wmas_pkg::job_req_t req,
	output logic               take,
	output logic               empty,
	input  logic               pop,
	output wmas_pkg::levels_t  levels
);
	import wmas_pkg::*;

	bk_state_t          state_q;
	bk_state_t          state_nxt;
	job_t               job_q;
	slot_t              age_q;
	logic [WINDOW_LEN-1:0] slot_vld_q;
	levels_t            levels_q;
	levels_t            level_nxt;
	logic               out_valid_q;
	logic               out_free;
	logic               acc_en;
	logic               div_en;
	logic               out_load;
	logic               hist_we;
	slot_t              rd_slot;
	logic [WEIGHT_W-1:0] weight;

	assign out_free = !out_valid_q || pop;
	assign rd_slot  = job_q.slot - age_q;
	assign weight   = WEIGHT_W'(WINDOW_LEN) - WEIGHT_W'(age_q);
	assign hist_we  = acc_en && (age_q == '0);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (req.valid)
					state_nxt = BK_ACC;
			end
			BK_ACC: begin
				if (age_q == slot_t'(WINDOW_LEN - 1))
					state_nxt = BK_DIV;
			end
			BK_DIV: state_nxt = BK_MUL;
			BK_MUL: begin
				if (out_free)
					state_nxt = req.valid ? BK_ACC : BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		take     = 1'b0;
		acc_en   = 1'b0;
		div_en   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: take = req.valid;
			BK_ACC:  acc_en = 1'b1;
			BK_DIV:  div_en = 1'b1;
			BK_MUL: begin
				out_load = out_free;
				take     = out_free && req.valid;
			end
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			age_q       <= '0;
			slot_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (take)
				age_q <= '0;
			else if (acc_en)
				age_q <= age_q + 1'b1;
			if (hist_we)
				slot_vld_q[job_q.slot] <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			job_q <= req.job;
		if (out_load)
			levels_q <= level_nxt;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		if (l < CHANNELS) begin : g_act
			sample_t                 hist_q [WINDOW_LEN];
			sample_t                 tap;
			logic [PROD_W-1:0]       prod;
			logic [ACC_W-1:0]        acc_q;
			logic [QUOT_PROD_W-1:0]  quot_s1;
			sample_t                 avg;
			logic [SCALED_W-1:0]     scaled;

			always_ff @(posedge clk) begin
				if (hist_we)
					hist_q[job_q.slot] <= job_q.samples[l];
			end

			// newest sample comes straight from the job; unwritten slots read as zero
			always_comb begin
				if (age_q == '0)
					tap = job_q.samples[l];
				else if (slot_vld_q[rd_slot])
					tap = hist_q[rd_slot];
				else
					tap = '0;
			end

			assign prod = tap * weight;

			always_ff @(posedge clk) begin
				if (acc_en)
					acc_q <= (age_q == '0) ? ACC_W'(prod) : acc_q + ACC_W'(prod);
				if (div_en)
					quot_s1 <= acc_q[ACC_W-1:DIV_PRE_SHIFT] * RECIP;
			end

			assign avg          = quot_s1[RECIP_SHIFT +: SAMPLE_W];
			assign scaled       = avg * SCALE_MUL;
			assign level_nxt[l] = scaled[SCALE_SHIFT +: LEVEL_W];
		end else begin : g_off
			assign level_nxt[l] = '0;
		end
	end

	assign empty  = !out_valid_q;
	assign levels = levels_q;

endmodule

// File: sv/weighted_moving_average_scale_8ch.sv
`timescale 1ns / 1ps
// Each transaction runs the back end's 8-tap accumulate over the per-channel ring,
// then one divide and one scale step, before its result shows (empty low); the back end
// takes the next transaction only once that result is loaded into the output register.
// A 2-entry input queue takes new transactions while the back end works or a result waits.
// Reset (arst_n low, asynchronous) empties both queues and marks all history slots as zero.

module weighted_moving_average_scale_8ch (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  wmas_pkg::sample_t    sample_ch0,
	input  wmas_pkg::sample_t    sample_ch1,
	input  wmas_pkg::sample_t    sample_ch2,
	input  wmas_pkg::sample_t    sample_ch3,
	input  wmas_pkg::sample_t    sample_ch4,
	input  wmas_pkg::sample_t    sample_ch5,
	input  wmas_pkg::sample_t    sample_ch6,
	input  wmas_pkg::sample_t    sample_ch7,
	output logic                 empty,
	input  logic                 pop,
	output wmas_pkg::level_t     level_ch0,
	output wmas_pkg::level_t     level_ch1,
	output wmas_pkg::level_t     level_ch2,
	output wmas_pkg::level_t     level_ch3,
	output wmas_pkg::level_t     level_ch4,
	output wmas_pkg::level_t     level_ch5,
	output wmas_pkg::level_t     level_ch6,
	output wmas_pkg::level_t     level_ch7
);
	import wmas_pkg::*;

	samples_t samples;
	levels_t  levels;
	job_req_t req;
	logic     take;

	assign samples[0] = sample_ch0;
	assign samples[1] = sample_ch1;
	assign samples[2] = sample_ch2;
	assign samples[3] = sample_ch3;
	assign samples[4] = sample_ch4;
	assign samples[5] = sample_ch5;
	assign samples[6] = sample_ch6;
	assign samples[7] = sample_ch7;

	wmas_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.samples (samples),
		.req     (req),
		.take    (take)
	);

	wmas_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.levels (levels)
	);

	assign level_ch0 = levels[0];
	assign level_ch1 = levels[1];
	assign level_ch2 = levels[2];
	assign level_ch3 = levels[3];
	assign level_ch4 = levels[4];
	assign level_ch5 = levels[5];
	assign level_ch6 = levels[6];
	assign level_ch7 = levels[7];

endmodule

// File: sv/wmas_chk.sv
`timescale 1ns / 1ps

module wmas_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input wmas_pkg::level_t level_ch0,
	input wmas_pkg::level_t level_ch1,
	input wmas_pkg::level_t level_ch2,
	input wmas_pkg::level_t level_ch3,
	input wmas_pkg::level_t level_ch4,
	input wmas_pkg::level_t level_ch5,
	input wmas_pkg::level_t level_ch6,
	input wmas_pkg::level_t level_ch7
);
	import wmas_pkg::*;

	localparam level_t LEVEL_MAX = LEVEL_W'(4999);

	// transactions accepted but not yet popped: 2 queued, 1 in work, 1 waiting
	logic [2:0] outstanding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({push && !full, pop && !empty})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> outstanding_q != '0)
		else $error("result shown with no transaction outstanding");

	a_full_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> outstanding_q >= 3'd2)
		else $error("full raised without a queued backlog");

	a_bounded_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'd4)
		else $error("more transactions outstanding than the block can hold");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (level_ch0 <= LEVEL_MAX) && (level_ch1 <= LEVEL_MAX)
			&& (level_ch2 <= LEVEL_MAX) && (level_ch3 <= LEVEL_MAX)
			&& (level_ch4 <= LEVEL_MAX) && (level_ch5 <= LEVEL_MAX)
			&& (level_ch6 <= LEVEL_MAX) && (level_ch7 <= LEVEL_MAX))
		else $error("level out of range");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(level_ch0) && $stable(level_ch7))
		else $error("waiting result changed before pop");

endmodule

bind weighted_moving_average_scale_8ch wmas_chk u_wmas_chk (.*);
